// ===== sv/hcb_pkg.sv =====
package hcb_pkg;

	localparam int MAX_SYMBOLS_DEF = 32;

	typedef struct packed {
		logic [15:0] weight;
		logic        last_weight;
	} item_t;

	typedef struct packed {
		logic [4:0]  symbol_index;
		logic [31:0] code_bits;
		logic [4:0]  code_length;
		logic        too_many;
		logic        last_code;
	} code_t;

endpackage

// ===== sv/huffman_code_builder_unit.sv =====
// Load: one weight per cycle, item_stall low while loading.
// Build: per merge i (n..2n-2) two scans over nodes 0..i-1 plus the CHECK, MERGE_A and
//   MERGE_B control states, all through one weight-memory read port.
// Emit: per symbol a WALK_START state, one WALK state per tree level walked, then EMIT until taken.
// Input stalls after the last weight until every code of the block has been emitted.
// Reset (arst_n low) clears counters, parent flags and the state; memories are not cleared.
module huffman_code_builder_unit #(
	parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  hcb_pkg::item_t item,
	output logic           code_valid,
	input  logic           code_stall,
	output hcb_pkg::code_t code
);
	import hcb_pkg::*;

	localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int I_W        = $clog2(NODE_COUNT + 1);
	localparam int LEN_W      = (I_W > 6) ? I_W : 6;
	localparam int NODE_W     = 16 + $clog2(MAX_SYMBOLS);

	localparam logic [2:0] ST_LOAD       = 3'd0;
	localparam logic [2:0] ST_CHECK      = 3'd1;
	localparam logic [2:0] ST_SCAN       = 3'd2;
	localparam logic [2:0] ST_MERGE_A    = 3'd3;
	localparam logic [2:0] ST_MERGE_B    = 3'd4;
	localparam logic [2:0] ST_WALK_START = 3'd5;
	localparam logic [2:0] ST_WALK       = 3'd6;
	localparam logic [2:0] ST_EMIT       = 3'd7;

	// parent link plus the branch bit of this node under its parent
	typedef struct packed {
		logic             right;
		logic [IDX_W-1:0] up;
	} link_t;

	logic [NODE_W-1:0] weight_mem [NODE_COUNT];
	link_t             link_mem   [NODE_COUNT];

	logic [2:0]            state_q;
	logic [I_W-1:0]        cnt_q, n_q, i_q, j_q;
	logic                  ovf_q;
	logic [NODE_COUNT-1:0] has_parent_q;
	logic                  pass_b_q, found_q;
	logic [IDX_W-1:0]      best_idx_q, a_q, b_q;
	logic [NODE_W-1:0]     best_w_q, wa_q, wb_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [NODE_W-1:0]     w_s1;
	link_t                 link_s1;
	logic [LEN_W-1:0]      s_q, len_q;
	logic [31:0]           code_q;

	logic                  w_we;
	logic [IDX_W-1:0]      w_addr;
	logic [NODE_W-1:0]     w_data;
	logic                  l_we;
	logic [IDX_W-1:0]      l_waddr, l_raddr;
	link_t                 l_data;
	logic [NODE_W-1:0]     sum_w;
	logic                  take;
	logic                  stored;
	logic                  build_done;
	logic                  is_last_sym;

	assign item_stall  = (state_q != ST_LOAD);
	assign code_valid  = (state_q == ST_EMIT);
	assign take        = item_valid && !item_stall;
	assign stored      = (cnt_q < I_W'(MAX_SYMBOLS));
	assign sum_w       = wa_q + wb_q;
	assign build_done  = ({1'b0, i_q} == ({n_q, 1'b0} - (I_W + 1)'(1)));
	assign is_last_sym = (s_q == LEN_W'(n_q) - LEN_W'(1));

	assign code.symbol_index = s_q[4:0];
	assign code.code_bits    = code_q;
	assign code.code_length  = len_q[4:0];
	assign code.too_many     = ovf_q;
	assign code.last_code    = is_last_sym;

	always_comb begin
		w_we    = 1'b0;
		w_addr  = cnt_q[IDX_W-1:0];
		w_data  = NODE_W'(item.weight);
		l_we    = 1'b0;
		l_waddr = a_q;
		l_data  = '{right: 1'b0, up: i_q[IDX_W-1:0]};
		l_raddr = link_s1.up;
		unique case (state_q)
			ST_LOAD: begin
				w_we = take && stored;
			end
			ST_MERGE_A: begin
				w_we   = 1'b1;
				w_addr = i_q[IDX_W-1:0];
				w_data = sum_w;
				l_we   = 1'b1;
			end
			ST_MERGE_B: begin
				l_we    = 1'b1;
				l_waddr = b_q;
				l_data  = '{right: 1'b1, up: i_q[IDX_W-1:0]};
			end
			ST_WALK_START: begin
				l_raddr = s_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_addr] <= w_data;
		end
		w_s1 <= weight_mem[j_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			link_mem[l_waddr] <= l_data;
		end
		link_s1 <= link_mem[l_raddr];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			cnt_q        <= '0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			ovf_q        <= 1'b0;
			has_parent_q <= '0;
			pass_b_q     <= 1'b0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_w_q     <= '0;
			a_q          <= '0;
			b_q          <= '0;
			wa_q         <= '0;
			wb_q         <= '0;
			vld_s1       <= 1'b0;
			s_q          <= '0;
			len_q        <= '0;
			code_q       <= '0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN) && (j_q < i_q);
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (stored) begin
							cnt_q <= cnt_q + I_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last_weight) begin
							n_q          <= stored ? cnt_q + I_W'(1) : cnt_q;
							i_q          <= stored ? cnt_q + I_W'(1) : cnt_q;
							has_parent_q <= '0;
							state_q      <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					j_q      <= '0;
					found_q  <= 1'b0;
					pass_b_q <= 1'b0;
					if (build_done) begin
						s_q     <= '0;
						state_q <= ST_WALK_START;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (j_q < i_q) begin
						j_q <= j_q + I_W'(1);
					end
					if (vld_s1 && !has_parent_q[idx_s1] && !(pass_b_q && idx_s1 == a_q)
							&& (!found_q || w_s1 < best_w_q)) begin
						found_q    <= 1'b1;
						best_idx_q <= idx_s1;
						best_w_q   <= w_s1;
					end
					if (j_q == i_q && !vld_s1) begin
						j_q     <= '0;
						found_q <= 1'b0;
						if (!pass_b_q) begin
							a_q      <= best_idx_q;
							wa_q     <= best_w_q;
							pass_b_q <= 1'b1;
						end else begin
							b_q     <= best_idx_q;
							wb_q    <= best_w_q;
							state_q <= ST_MERGE_A;
						end
					end
				end
				ST_MERGE_A: begin
					has_parent_q[a_q] <= 1'b1;
					state_q           <= ST_MERGE_B;
				end
				ST_MERGE_B: begin
					has_parent_q[b_q] <= 1'b1;
					i_q               <= i_q + I_W'(1);
					state_q           <= ST_CHECK;
				end
				ST_WALK_START: begin
					code_q <= '0;
					len_q  <= '0;
					// link read of this symbol is issued now
					state_q <= has_parent_q[s_q[IDX_W-1:0]] ? ST_WALK : ST_EMIT;
				end
				ST_WALK: begin
					if (len_q < LEN_W'(32)) begin
						code_q[len_q[4:0]] <= link_s1.right;
					end
					len_q <= len_q + LEN_W'(1);
					// next level read goes out on link_s1.up in this cycle
					if (!has_parent_q[link_s1.up]) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!code_stall) begin
						if (is_last_sym) begin
							cnt_q        <= '0;
							ovf_q        <= 1'b0;
							has_parent_q <= '0;
							state_q      <= ST_LOAD;
						end else begin
							s_q     <= s_q + LEN_W'(1);
							state_q <= ST_WALK_START;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== dv/huffman_code_builder_unit_tb.sv =====
`timescale 1ns / 100ps

module huffman_code_builder_unit_tb;

	localparam int MAX_SYM        = hcb_pkg::MAX_SYMBOLS_DEF;
	localparam int NODES          = 2 * MAX_SYM - 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 70;

	typedef enum {W_FULL, W_LOW, W_TOP} wkind_t;

	// Expected code table, rebuilt from the loaded weights on every last transfer
	class code_scoreboard_t;
		logic [15:0]    weights [MAX_SYM];
		int             loaded = 0;
		bit             dropped = 1'b0;
		logic [20:0]    node_sum [NODES];
		int             node_up [NODES];   // parent index + 1, 0 when unlinked
		int             node_lo [NODES];   // left child index + 1
		hcb_pkg::code_t expected [$];
		int             errors = 0;
		int             checked = 0;

		// parentless node of least weight below lim, lowest index on ties
		function int least_free(int lim, int skip);
			int best  = 0;
			bit found = 1'b0;
			for (int j = 0; j < lim; j++) begin
				if (j != skip && node_up[j] == 0 && (!found || node_sum[j] < node_sum[best])) begin
					best  = j;
					found = 1'b1;
				end
			end
			return best;
		endfunction

		function void build_codes();
			int             a, b, c, f, len;
			logic [31:0]    bits;
			hcb_pkg::code_t cw;
			foreach (node_up[k]) begin
				node_up[k] = 0;
				node_lo[k] = 0;
			end
			for (int k = 0; k < loaded; k++) node_sum[k] = {5'd0, weights[k]};
			for (int i = loaded; i + 1 < 2 * loaded; i++) begin
				a = least_free(i, NODES);
				b = least_free(i, a);
				node_up[a]  = i + 1;
				node_up[b]  = i + 1;
				node_lo[i]  = a + 1;
				node_sum[i] = node_sum[a] + node_sum[b];
			end
			for (int s = 0; s < loaded; s++) begin
				c    = s;
				len  = 0;
				bits = '0;
				while (node_up[c] != 0) begin
					f = node_up[c] - 1;
					if (len < 32) bits[len] = (node_lo[f] != c + 1);
					len++;
					c = f;
				end
				cw.symbol_index = 5'(s);
				cw.code_bits    = bits;
				cw.code_length  = 5'(len);
				cw.too_many     = dropped;
				cw.last_code    = (s == loaded - 1);
				expected.push_back(cw);
			end
		endfunction

		function void note_item(hcb_pkg::item_t it);
			if (loaded < MAX_SYM) begin
				weights[loaded] = it.weight;
				loaded++;
			end else begin
				dropped = 1'b1;
			end
			if (it.last_weight) begin
				build_codes();
				loaded  = 0;
				dropped = 1'b0;
			end
		endfunction

		function void cmp_field(string fld, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, want, got);
				errors++;
			end
		endfunction

		function void check_code(hcb_pkg::code_t got);
			hcb_pkg::code_t want;
			if (expected.size() == 0) begin
				$display("%0t: code transfer with none expected, expected none actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected.pop_front();
			checked++;
			cmp_field("symbol_index", want.symbol_index, got.symbol_index);
			cmp_field("code_bits", want.code_bits, got.code_bits);
			cmp_field("code_length", want.code_length, got.code_length);
			cmp_field("too_many", want.too_many, got.too_many);
			cmp_field("last_code", want.last_code, got.last_code);
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	hcb_pkg::item_t item = '0;
	logic           code_valid;
	logic           code_stall = 1'b0;
	hcb_pkg::code_t code;

	code_scoreboard_t sb;
	logic [15:0]    blk [$];
	bit             calm = 1'b0;
	int             stuck_cycles = 0;
	int             items_sent = 0;
	int             blocks_sent = 0;
	int             overfull_blocks = 0;
	int             random_start;

	huffman_code_builder_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		code_stall <= !calm && ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_item(item);
			if (code_valid && !code_stall) sb.check_code(code);
		end
		if ((item_valid && !item_stall) || (code_valid && !code_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_item(input logic [15:0] w, input bit lst);
		while (!calm && $urandom_range(99) < 38) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{weight: w, last_weight: lst};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_block();
		foreach (blk[k]) send_item(blk[k], k == blk.size() - 1);
		blocks_sent++;
		if (blk.size() > MAX_SYM) overfull_blocks++;
		blk.delete();
	endtask

	task automatic fill_random(input int n, input wkind_t kind);
		for (int k = 0; k < n; k++) begin
			case (kind)
				W_LOW:   blk.push_back(16'($urandom_range(3)));
				W_TOP:   blk.push_back(16'hFFFF - 16'($urandom_range(3)));
				default: blk.push_back(16'($urandom_range(16'hFFFF)));
			endcase
		end
	endtask

	task automatic drain_codes();
		// let the last input transfer reach the scoreboard first
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [15:0] fa, fb;
		sb = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// single symbol, extremes, ties, alternating bits, powers of two
		blk = '{16'h0000};                                send_block();
		blk = '{16'hFFFF};                                send_block();
		blk = '{16'hFFFF, 16'h0000};                      send_block();
		blk = '{16'h0007, 16'h0007};                      send_block();
		blk = '{16'hAAAA, 16'h5555, 16'h0000};            send_block();
		blk = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};  send_block();
		blk = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0};       send_block();
		blk = '{16'h1, 16'h2, 16'h4, 16'h8, 16'h10};      send_block();
		item_valid <= 1'b0;
		drain_codes();

		random_start = items_sent;
		// over capacity: weights past the store size are dropped, last one included
		fill_random(34, W_FULL);
		send_block();
		item_valid <= 1'b0;
		drain_codes();

		// Fibonacci weights give a one-sided tree with long codes
		fa = 16'd1;
		fb = 16'd1;
		for (int k = 0; k < 24; k++) begin
			blk.push_back(fa);
			{fa, fb} = {fb, 16'(fa + fb)};
		end
		send_block();

		random_start = items_sent;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			calm = (items_sent >= random_start + 20) && (items_sent < random_start + 50);
			if ($urandom_range(99) < 8)
				fill_random($urandom_range(32, 35), W_FULL);
			else
				fill_random($urandom_range(1, 10), wkind_t'($urandom_range(2)));
			send_block();
		end
		calm = 1'b0;
		item_valid <= 1'b0;

		drain_codes();
		repeat (300) @(posedge clk);
		$display("Run covered %0d weights in %0d blocks (%0d over capacity), %0d codes checked",
			items_sent, blocks_sent, overfull_blocks, sb.checked);
		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/hcb_pkg.sv
sv/huffman_code_builder_unit.sv
dv/huffman_code_builder_unit_tb.sv
